// ===== src/ffpa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared constants, codes and controller/datapath types of the first-fit
// page allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

    // Geometry of the managed page store
    localparam int NUM_PAGES  = 1024;
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int IDX_W      = $clog2(NUM_PAGES);
    localparam int CNT_W      = 11;
    localparam int ADDR_W     = 64;
    localparam int DIFF_IDX_W = ADDR_W - PAGE_SHIFT;
    localparam int ST_W       = 2;

    // Stream and register port widths
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 64;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 64;

    localparam logic [CNT_W-1:0] PAGES_MAX   = CNT_W'(NUM_PAGES);
    localparam logic [CNT_W-1:0] RANGE_RESET = 11'd1024;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD_FREE = 2'd2;

    // Request kinds
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Register select (paddr bit 3, registers at 8-byte spacing)
    localparam logic REG_HEAP_BASE  = 1'b0;
    localparam logic REG_PAGE_RANGE = 1'b1;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_MARK,
        S_FSUB,
        S_FCHK,
        S_CLEAR,
        S_RESP
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic            load_req;
        logic            scan_start;
        logic            scan_run;
        logic            mark_start;
        logic            clr_start;
        logic            free_sub;
        logic            walk_en;
        logic            walk_val;
        logic            out_load;
        logic [ST_W-1:0] out_status;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic op_free;
        logic cnt_zero;
        logic found;
        logic exhausted;
        logic walk_last;
        logic free_bad;
        logic out_busy;
    } t_dp_stat;

endpackage

// ===== src/ffpa_regs.sv =====
// ----------------------------------------------------------------------------
// ffpa_regs
// Register bank: heap base and managed page range, written over the
// register port; supplies the effective page limit.
// ----------------------------------------------------------------------------
module ffpa_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ffpa_pkg::PADDR_W-1:0]  paddr,
    input  logic [ffpa_pkg::PDATA_W-1:0]  pwdata,
    output logic [ffpa_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output logic [ffpa_pkg::ADDR_W-1:0]   o_heap_base,
    output logic [ffpa_pkg::CNT_W-1:0]    o_limit
);

    logic [ffpa_pkg::ADDR_W-1:0] r_heap_base;
    logic [ffpa_pkg::CNT_W-1:0]  r_range;
    logic                        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // Write registers on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base <= '0;
            r_range     <= ffpa_pkg::RANGE_RESET;
        end else if (wr_en) begin
            if (paddr[3] == ffpa_pkg::REG_HEAP_BASE) begin
                r_heap_base <= pwdata;
            end else begin
                r_range <= pwdata[ffpa_pkg::CNT_W-1:0];
            end
        end
    end

    // Read back
    always_comb begin
        if (paddr[3] == ffpa_pkg::REG_HEAP_BASE) begin
            prdata = r_heap_base;
        end else begin
            prdata = {{(ffpa_pkg::PDATA_W-ffpa_pkg::CNT_W){1'b0}}, r_range};
        end
    end

    // Clamp range to the store depth
    assign o_heap_base = r_heap_base;
    assign o_limit     = (r_range > ffpa_pkg::PAGES_MAX) ? ffpa_pkg::PAGES_MAX : r_range;

endmodule

// ===== src/ffpa_dp.sv =====
// ----------------------------------------------------------------------------
// ffpa_dp
// Datapath: page-used bitmap memory, pipelined first-fit scan, run walker
// for marking and clearing, free range check and result register.
// ----------------------------------------------------------------------------
module ffpa_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ffpa_pkg::t_dp_cmd                 i_cmd,
    output ffpa_pkg::t_dp_stat                o_stat,
    input  logic [ffpa_pkg::ADDR_W-1:0]       i_heap_base,
    input  logic [ffpa_pkg::CNT_W-1:0]        i_limit,
    input  logic                              i_req_op,
    input  logic [ffpa_pkg::CNT_W-1:0]        i_req_count,
    input  logic [ffpa_pkg::ADDR_W-1:0]       i_req_addr,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [ffpa_pkg::ADDR_W-1:0]       o_out_addr,
    output logic [ffpa_pkg::ST_W-1:0]         o_out_status
);

    // Bitmap store
    logic                         r_page_used [ffpa_pkg::NUM_PAGES];
    logic                         r_rd_data;

    // Request
    logic                         r_op;
    logic [ffpa_pkg::CNT_W-1:0]   r_count;
    logic [ffpa_pkg::ADDR_W-1:0]  r_addr;

    // Scan
    logic [ffpa_pkg::CNT_W-1:0]   r_issue;
    logic                         r_vld;
    logic [ffpa_pkg::IDX_W-1:0]   r_didx;
    logic [ffpa_pkg::CNT_W-1:0]   r_run;
    logic [ffpa_pkg::IDX_W-1:0]   r_start;
    logic [ffpa_pkg::CNT_W-1:0]   n_run;
    logic [ffpa_pkg::IDX_W-1:0]   n_start;
    logic                         issue_ok;

    // Walker
    logic [ffpa_pkg::IDX_W-1:0]   r_walk;
    logic [ffpa_pkg::CNT_W-1:0]   r_remain;

    // Free check
    logic [ffpa_pkg::ADDR_W-1:0]  r_diff;
    logic                         r_borrow;
    logic [ffpa_pkg::DIFF_IDX_W-1:0] free_idx;
    logic [ffpa_pkg::CNT_W:0]     free_end;

    // Result
    logic [ffpa_pkg::ADDR_W-1:0]  r_alloc_addr;
    logic                         r_out_valid;
    logic [ffpa_pkg::ADDR_W-1:0]  r_out_addr;
    logic [ffpa_pkg::ST_W-1:0]    r_out_status;

    // Memory write by the walker, read by the scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_en) begin
            r_page_used[r_walk] <= i_cmd.walk_val;
        end
        r_rd_data <= r_page_used[r_issue[ffpa_pkg::IDX_W-1:0]];
    end

    // Scan evaluation of the page returned last cycle
    assign issue_ok = (r_issue < i_limit);

    always_comb begin
        if (r_rd_data) begin
            n_run = '0;
        end else begin
            n_run = ffpa_pkg::CNT_W'(r_run + 1'b1);
        end
        n_start = (r_run == '0) ? r_didx : r_start;
    end

    // Free index and range end
    assign free_idx = r_diff[ffpa_pkg::ADDR_W-1:ffpa_pkg::PAGE_SHIFT];
    assign free_end = {1'b0, free_idx[ffpa_pkg::CNT_W-1:0]} + {1'b0, r_count};

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk      <= '0;
            r_remain    <= ffpa_pkg::PAGES_MAX;
            r_issue     <= '0;
            r_vld       <= 1'b0;
            r_run       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Advance the scan
            if (i_cmd.scan_start) begin
                r_issue <= '0;
                r_vld   <= 1'b0;
                r_run   <= '0;
            end else if (i_cmd.scan_run) begin
                if (issue_ok) begin
                    r_issue <= ffpa_pkg::CNT_W'(r_issue + 1'b1);
                end
                r_vld <= issue_ok;
                if (r_vld) begin
                    r_run <= n_run;
                end
            end

            // Load or advance the walker
            if (i_cmd.mark_start) begin
                r_walk   <= n_start;
                r_remain <= r_count;
            end else if (i_cmd.clr_start) begin
                r_walk   <= free_idx[ffpa_pkg::IDX_W-1:0];
                r_remain <= r_count;
            end else if (i_cmd.walk_en) begin
                r_walk   <= ffpa_pkg::IDX_W'(r_walk + 1'b1);
                r_remain <= ffpa_pkg::CNT_W'(r_remain - 1'b1);
            end

            // Hold the result until taken
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_op    <= i_req_op;
            r_count <= i_req_count;
            r_addr  <= i_req_addr;
        end
        if (i_cmd.scan_run) begin
            r_didx <= r_issue[ffpa_pkg::IDX_W-1:0];
            if (r_vld) begin
                r_start <= n_start;
            end
        end
        if (i_cmd.mark_start) begin
            r_alloc_addr <= i_heap_base
                          + {{(ffpa_pkg::ADDR_W-ffpa_pkg::IDX_W-ffpa_pkg::PAGE_SHIFT){1'b0}},
                             n_start, {ffpa_pkg::PAGE_SHIFT{1'b0}}};
        end
        if (i_cmd.free_sub) begin
            {r_borrow, r_diff} <= {1'b0, r_addr} - {1'b0, i_heap_base};
        end
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            if (i_cmd.out_status == ffpa_pkg::ST_OK && r_op == ffpa_pkg::OP_ALLOC) begin
                r_out_addr <= r_alloc_addr;
            end else begin
                r_out_addr <= '0;
            end
        end
    end

    // Status back to the controller
    always_comb begin
        o_stat.op_free   = (r_op == ffpa_pkg::OP_FREE);
        o_stat.cnt_zero  = (r_count == '0);
        o_stat.found     = r_vld & ~r_rd_data & (n_run == r_count);
        o_stat.exhausted = ~r_vld & ~issue_ok;
        o_stat.walk_last = (r_remain == ffpa_pkg::CNT_W'(1));
        o_stat.free_bad  = r_borrow
                         | (|free_idx[ffpa_pkg::DIFF_IDX_W-1:ffpa_pkg::CNT_W])
                         | (free_end > {1'b0, i_limit});
        o_stat.out_busy  = r_out_valid & ~i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_addr   = r_out_addr;
    assign o_out_status = r_out_status;

endmodule

// ===== src/ffpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffpa_ctrl
// Controller: sequences the clearing pass, scan, mark, free check, clear
// and result hand-off over the datapath.
// ----------------------------------------------------------------------------
module ffpa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    input  ffpa_pkg::t_dp_stat  i_stat,
    output ffpa_pkg::t_dp_cmd   o_cmd
);

    ffpa_pkg::t_state            r_state;
    ffpa_pkg::t_state            n_state;
    logic [ffpa_pkg::ST_W-1:0]   r_resp;
    logic [ffpa_pkg::ST_W-1:0]   n_resp;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffpa_pkg::S_INIT;
            r_resp  <= ffpa_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_resp  <= n_resp;
        end
    end

    // Next state and commands
    always_comb begin
        n_state          = r_state;
        n_resp           = r_resp;
        o_req_ready      = 1'b0;
        o_cmd            = '0;
        o_cmd.out_status = r_resp;

        unique case (r_state)
            ffpa_pkg::S_INIT: begin
                // Sweep zeros through the bitmap
                o_cmd.walk_en = 1'b1;
                if (i_stat.walk_last) begin
                    n_state = ffpa_pkg::S_IDLE;
                end
            end
            ffpa_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = ffpa_pkg::S_DECODE;
                end
            end
            ffpa_pkg::S_DECODE: begin
                if (i_stat.op_free) begin
                    n_state = ffpa_pkg::S_FSUB;
                end else if (i_stat.cnt_zero) begin
                    n_resp  = ffpa_pkg::ST_NO_SPACE;
                    n_state = ffpa_pkg::S_RESP;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = ffpa_pkg::S_SCAN;
                end
            end
            ffpa_pkg::S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_stat.found) begin
                    o_cmd.mark_start = 1'b1;
                    n_state          = ffpa_pkg::S_MARK;
                end else if (i_stat.exhausted) begin
                    n_resp  = ffpa_pkg::ST_NO_SPACE;
                    n_state = ffpa_pkg::S_RESP;
                end
            end
            ffpa_pkg::S_MARK: begin
                o_cmd.walk_en  = 1'b1;
                o_cmd.walk_val = 1'b1;
                if (i_stat.walk_last) begin
                    n_resp  = ffpa_pkg::ST_OK;
                    n_state = ffpa_pkg::S_RESP;
                end
            end
            ffpa_pkg::S_FSUB: begin
                o_cmd.free_sub = 1'b1;
                n_state        = ffpa_pkg::S_FCHK;
            end
            ffpa_pkg::S_FCHK: begin
                if (i_stat.free_bad) begin
                    n_resp  = ffpa_pkg::ST_BAD_FREE;
                    n_state = ffpa_pkg::S_RESP;
                end else if (i_stat.cnt_zero) begin
                    n_resp  = ffpa_pkg::ST_OK;
                    n_state = ffpa_pkg::S_RESP;
                end else begin
                    o_cmd.clr_start = 1'b1;
                    n_state         = ffpa_pkg::S_CLEAR;
                end
            end
            ffpa_pkg::S_CLEAR: begin
                o_cmd.walk_en = 1'b1;
                if (i_stat.walk_last) begin
                    n_resp  = ffpa_pkg::ST_OK;
                    n_state = ffpa_pkg::S_RESP;
                end
            end
            ffpa_pkg::S_RESP: begin
                // Wait for the result register to free up
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ffpa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ffpa_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/first_fit_page_allocator_unit.sv =====
// Allocate scans the bitmap until a run fits or all managed pages are scanned.
// Throughput: one request at a time, the next taken once the result is loaded;
//   the bitmap is read at one page and written at one page per cycle.
// Reset: synchronous, active low; afterwards a clearing pass over
//   the bitmap runs with s_axis_tready low (register writes are still taken).
// ----------------------------------------------------------------------------
// first_fit_page_allocator_unit
// Bitmap first-fit page allocator: allocates and frees runs of pages.
// ----------------------------------------------------------------------------
module first_fit_page_allocator_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request: [10:0] page_count, [74:11] free_address, [79:75] zero
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [ffpa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // request: [0] operation
    input  logic                                s_axis_tuser,
    // result: [63:0] run_address
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [ffpa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // result: [1:0] status
    output logic [ffpa_pkg::ST_W-1:0]           m_axis_tuser,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ffpa_pkg::PADDR_W-1:0]        paddr,
    input  logic [ffpa_pkg::PDATA_W-1:0]        pwdata,
    output logic [ffpa_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    logic [ffpa_pkg::ADDR_W-1:0] heap_base;
    logic [ffpa_pkg::CNT_W-1:0]  limit;
    ffpa_pkg::t_dp_cmd           cmd;
    ffpa_pkg::t_dp_stat          stat;

    ffpa_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_heap_base (heap_base),
        .o_limit     (limit)
    );

    ffpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ffpa_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_heap_base  (heap_base),
        .i_limit      (limit),
        .i_req_op     (s_axis_tuser),
        .i_req_count  (s_axis_tdata[ffpa_pkg::CNT_W-1:0]),
        .i_req_addr   (s_axis_tdata[ffpa_pkg::CNT_W+ffpa_pkg::ADDR_W-1:ffpa_pkg::CNT_W]),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_addr   (m_axis_tdata),
        .o_out_status (m_axis_tuser)
    );

endmodule

// ===== src/ffpa_checker.sv =====
// ----------------------------------------------------------------------------
// ffpa_checker
// Port-level checks of the page allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffpa_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [ffpa_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic [ffpa_pkg::ST_W-1:0]         m_axis_tuser
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // Only defined status codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ffpa_pkg::ST_OK
                        || m_axis_tuser == ffpa_pkg::ST_NO_SPACE
                        || m_axis_tuser == ffpa_pkg::ST_BAD_FREE))
        else $error("undefined status code");

    // Failed requests carry a zero address
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ffpa_pkg::ST_OK |-> m_axis_tdata == '0)
        else $error("failed request with nonzero address");

    // Clearing pass blocks requests right after reset
    a_init_block: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("request taken during clearing pass");

    // One request in work at a time
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while busy");

endmodule

bind first_fit_page_allocator_unit ffpa_checker u_ffpa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
